### rtl/tefa_pkg.sv
// Shared types and constants for the tape extent first-fit allocator.
// Used by tefa_table and tape_extent_first_fit_allocator; depends on nothing.
`default_nettype none

package tefa_pkg;

	// Input item, one transfer on the input channel.
	typedef struct packed {
		logic        mode;
		logic [8:0]  slot;
		logic        slot_live;
		logic [15:0] slot_start;
		logic [23:0] slot_size_bytes;
		logic [15:0] request_blocks;
	} tefa_in_t;

	// Result item, one transfer on the output channel.
	typedef struct packed {
		logic [15:0] alloc_start;
		logic        full_res;
	} tefa_out_t;

	// One stored directory slot. The end block is kept instead of the length,
	// and active folds the live flag together with a nonzero length.
	typedef struct packed {
		logic        active;
		logic [15:0] start_blk;
		logic [16:0] end_blk;
	} tefa_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} tefa_state_t;

	localparam logic        MODE_WRITE    = 1'b0;
	localparam logic        MODE_ALLOC    = 1'b1;
	localparam int          BLOCK_SHIFT   = 9;
	localparam logic [7:0]  DIR_LEN_RESET = 8'd24;
	localparam logic [15:0] MAX_BLOCK     = 16'hFFFF;

endpackage

`default_nettype wire

### rtl/tefa_table.sv
// Directory slot memory with one write port and one registered read port.
// Runs a clearing sweep after reset. Depends on tefa_pkg.
`default_nettype none

module tefa_table #(
	parameter int TABLE_SLOTS = 512,
	localparam int IDX_W = $clog2(TABLE_SLOTS),
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire tefa_pkg::tefa_entry_t wr_entry,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output tefa_pkg::tefa_entry_t     rd_data,
	output logic                      clr_busy
);
	import tefa_pkg::*;

	tefa_entry_t       mem [TABLE_SLOTS];
	tefa_entry_t       rd_data_q;
	logic [CNT_W-1:0]  clr_cnt_q;

	assign clr_busy = (clr_cnt_q != CNT_W'(TABLE_SLOTS));
	assign rd_data  = rd_data_q;

	// The sweep walks every slot once after reset and marks it inactive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clr_busy) begin
			clr_cnt_q <= clr_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem[clr_cnt_q[IDX_W-1:0]] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/tape_extent_first_fit_allocator.sv
// Operation: a slot write gives no result. An allocate item reads every table slot through
// the single memory read port in each pass and repeats passes until one no longer moves
// the candidate; the result is then loaded into the output register.
// Flow: one allocate item at a time, while write items are taken in idle and leave it idle;
// after an allocate, the next item is taken the cycle after its result is loaded.
// Reset: arst_n clears control state and the directory length (24), then a sweep clears the
// slot table while input stays stalled; configuration writes are taken meanwhile.
`default_nettype none

module tape_extent_first_fit_allocator #(
	parameter int TABLE_SLOTS = 512
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire tefa_pkg::tefa_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output tefa_pkg::tefa_out_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data
);
	import tefa_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	// Wide enough for both the 9-bit slot field and the slot count itself.
	localparam int WIDE_W = (CNT_W > 9) ? CNT_W : 9;

	// Sequencer and datapath registers.
	tefa_state_t       state_q, state_d;
	logic [7:0]        dir_len_q;
	logic [16:0]       base_q;
	logic [15:0]       want_q;
	logic [CNT_W-1:0]  issue_cnt_q;
	logic              rd_vld_s1;
	logic              moved_q;
	logic              out_valid_q;
	tefa_out_t         out_data_q;

	// Combinational controls.
	logic              in_accept;
	logic              alloc_go;
	logic              issue;
	logic              hit;
	logic              pass_end;
	logic              out_load;
	logic              out_xfer;
	logic              clr_busy;

	// Slot write path.
	logic [WIDE_W-1:0] slot_wide;
	logic              slot_in_range;
	logic [15:0]       new_blocks;
	logic              wr_en;
	tefa_entry_t       wr_entry;
	tefa_entry_t       rd_data;
	logic [17:0]       cand_limit;

	// The user must write the configuration register only while the block is idle; the block
	// itself does not enforce this, and its port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_len_q <= DIR_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dir_len_q <= cfg_data;
		end
	end

	// Input handshake. Nothing is taken while the table is being cleared or
	// while an allocation is still being worked on.
	assign in_stall  = (state_q != ST_IDLE) || clr_busy;
	assign in_accept = in_valid && !in_stall;
	assign alloc_go  = in_accept && (in_data.mode == MODE_ALLOC);

	// A write item converts the byte size into whole 512-byte blocks, rounding up,
	// and stores the end block so the scan needs no add on the table side.
	// Slots at or above the table depth are dropped.
	assign slot_wide     = WIDE_W'(in_data.slot);
	assign slot_in_range = slot_wide < WIDE_W'(TABLE_SLOTS);
	assign new_blocks    = {1'b0, in_data.slot_size_bytes[23:BLOCK_SHIFT]}
		+ 16'(|in_data.slot_size_bytes[BLOCK_SHIFT-1:0]);
	assign wr_en         = in_accept && (in_data.mode == MODE_WRITE) && slot_in_range;

	always_comb begin
		wr_entry.active    = in_data.slot_live && (new_blocks != 16'd0);
		wr_entry.start_blk = in_data.slot_start;
		wr_entry.end_blk   = {1'b0, in_data.slot_start} + {1'b0, new_blocks};
	end

	tefa_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (slot_wide[IDX_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (issue),
		.rd_addr  (issue_cnt_q[IDX_W-1:0]),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	// The scan issues one slot read per cycle. The entry comes back through the registered
	// read port and is checked against the current candidate by the one shared compare unit:
	// a live extent that starts before the candidate end and ends after the
	// candidate start pushes the candidate to its end block.
	assign issue      = (state_q == ST_SCAN) && (issue_cnt_q != CNT_W'(TABLE_SLOTS));
	assign cand_limit = {1'b0, base_q} + {2'b00, want_q};
	assign hit        = rd_vld_s1 && rd_data.active
		&& ({2'b00, rd_data.start_blk} < cand_limit)
		&& (rd_data.end_blk > base_q);
	// A pass is over once every read has been issued and the last one checked.
	assign pass_end   = (state_q == ST_SCAN) && !issue && !rd_vld_s1;

	// The output register lets a result wait while the next item is taken.
	assign out_xfer = out_valid_q && !out_stall;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (alloc_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Another pass is needed whenever this one moved the candidate.
				if (pass_end && !moved_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			moved_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (alloc_go || pass_end) begin
				issue_cnt_q <= '0;
			end else if (issue) begin
				issue_cnt_q <= issue_cnt_q + CNT_W'(1);
			end
			if (alloc_go || pass_end) begin
				moved_q <= 1'b0;
			end else if (hit) begin
				moved_q <= 1'b1;
			end
		end
	end

	// The candidate starts one block past the boot block and directory.
	always_ff @(posedge clk) begin
		if (alloc_go) begin
			base_q <= 17'(dir_len_q) + 17'd1;
			want_q <= in_data.request_blocks;
		end else if (hit) begin
			base_q <= rd_data.end_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// A start beyond the last tape block is reported as full and saturated.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.full_res    <= base_q[16];
			out_data_q.alloc_start <= base_q[16] ? MAX_BLOCK : base_q[15:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// The candidate only ever moves forward while a scan runs.
	a_base_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (base_q >= $past(base_q)))
		else $error("candidate start moved backward during a scan");

	// A result is only produced after a pass that found no conflict.
	a_finish_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!moved_q && !rd_vld_s1))
		else $error("scan finished with a conflict still pending");

	// The table sweep after reset never overlaps an allocation scan.
	a_no_scan_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !clr_busy)
		else $error("allocation scan ran while the table was being cleared");

	// A full result always carries the saturated start block.
	a_full_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.full_res) |-> (out_data.alloc_start == MAX_BLOCK))
		else $error("full result without a saturated start block");
`endif

endmodule

`default_nettype wire
